FILE: rtl/snmp_ber_header_parser_assert.svh
// ----------------------------------------------------------------------------
// SNMP BER header parser assertion macros
// Clocked property checks shared by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef SNMP_BER_HEADER_PARSER_ASSERT_SVH
`define SNMP_BER_HEADER_PARSER_ASSERT_SVH

// Checked only outside reset
`define SBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included
`define SBP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/sbp_pkg.sv
// ----------------------------------------------------------------------------
// SNMP BER header parser package
// Payload structs, parse phases, tag and status codes.
// ----------------------------------------------------------------------------
package sbp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } sbp_in_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         community_byte;
    logic [2:0]         status;
    logic [31:0]        version;
    logic [7:0]         pdu_type;
    logic signed [31:0] request_id;
    logic signed [31:0] error_status;
    logic signed [31:0] error_index;
    logic [31:0]        agent_address;
    logic [7:0]         community_length;
  } sbp_out_t;

  typedef enum logic [4:0] {
    PH_SEQ_TAG, PH_TOTAL_LEN, PH_VER_TAG, PH_VER_LEN, PH_VER_BODY,
    PH_COM_TAG, PH_COM_LEN, PH_COM_BODY, PH_PDU_TYPE, PH_PDU_LEN,
    PH_INT_TAG, PH_INT_LEN, PH_INT_BODY, PH_OID_TAG, PH_OID_LEN,
    PH_OID_BODY, PH_IP_TAG, PH_IP_LEN, PH_IP_BODY, PH_DONE, PH_HALT
  } sbp_phase_t;

  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_INTEGER  = 8'h02;
  localparam logic [7:0] TAG_OCTETS   = 8'h04;
  localparam logic [7:0] TAG_OID      = 8'h06;
  localparam logic [7:0] TAG_IPADDR   = 8'h40;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SEQ    = 3'd1;
  localparam logic [2:0] ST_LEN_MIS   = 3'd2;
  localparam logic [2:0] ST_VER_TAG   = 3'd3;
  localparam logic [2:0] ST_COM_TAG   = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;
  localparam logic [2:0] ST_INT_TAG   = 3'd6;
  localparam logic [2:0] ST_TRAP_FMT  = 3'd7;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESPONSE_CODE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRAP_CODE     = 8'd1;

  localparam logic [7:0] RESPONSE_CODE_RST = 8'hA2;
  localparam logic [7:0] TRAP_CODE_RST     = 8'hA4;

  localparam logic [8:0] BYTE_COUNT_MAX = 9'd511;
  localparam logic [1:0] INT_LAST       = 2'd2;

endpackage

FILE: rtl/snmp_ber_header_parser.sv
// ----------------------------------------------------------------------------
// SNMP BER header parser
// Byte-wide SNMP v1 message header parser with community byte streaming.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_ready   sbp_in_t  (byte, end of message)
//  out_     output     out_valid/out_ready sbp_out_t (community byte or summary)
//  cfg_     input      cfg_valid/cfg_ready index, 8-bit PDU code
//
//  One byte per cycle while in_ready is high: the parse phase update and
//  shift-accumulate sit between the parse state registers and the result
//  register, or the skid entry while the output is held.
//  An output register plus a one-entry skid stage keep input flowing while
//  a result waits; input stalls only while the skid entry is full.
//  Reset is synchronous; cfg_ready is always high.
module snmp_ber_header_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sbp_pkg::sbp_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sbp_pkg::sbp_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [7:0]                        cfg_data
);
  import sbp_pkg::*;

  `include "snmp_ber_header_parser_assert.svh"

  logic [7:0]  resp_code_r, trap_code_r;

  sbp_phase_t  phase_r, phase_nxt;
  logic [8:0]  count_r, count_nxt;
  logic [7:0]  total_r, total_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [31:0] ver_r, ver_nxt;
  logic [7:0]  pdu_r, pdu_nxt;
  logic [7:0]  comlen_r, comlen_nxt;
  logic [31:0] int_r [3];
  logic [31:0] int_nxt [3];
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] addr_r, addr_nxt;

  logic        in_fire, emit, res_valid;
  logic [7:0]  b;
  logic [2:0]  status;
  sbp_out_t    res;

  sbp_out_t    out_r, skid_r;
  logic        out_valid_r, skid_valid_r;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign b         = in_data.data_byte;

  always_comb begin
    phase_nxt  = phase_r;
    total_nxt  = total_r;
    left_nxt   = left_r;
    err_nxt    = err_r;
    ver_nxt    = ver_r;
    pdu_nxt    = pdu_r;
    comlen_nxt = comlen_r;
    int_nxt    = int_r;
    idx_nxt    = idx_r;
    addr_nxt   = addr_r;
    emit       = 1'b0;
    count_nxt  = (count_r == BYTE_COUNT_MAX) ? count_r : count_r + 9'd1;
    unique case (phase_r)
      PH_SEQ_TAG: begin
        if (b != TAG_SEQUENCE) begin
          err_nxt = ST_NO_SEQ; phase_nxt = PH_HALT;
        end else phase_nxt = PH_TOTAL_LEN;
      end
      PH_TOTAL_LEN: begin
        total_nxt = b; phase_nxt = PH_VER_TAG;
      end
      PH_VER_TAG: begin
        if (b != TAG_INTEGER) begin
          err_nxt = ST_VER_TAG; phase_nxt = PH_HALT;
        end else phase_nxt = PH_VER_LEN;
      end
      PH_VER_LEN: begin
        left_nxt  = b;
        phase_nxt = (b == 8'd0) ? PH_COM_TAG : PH_VER_BODY;
      end
      PH_VER_BODY: begin
        ver_nxt  = {ver_r[23:0], b};
        left_nxt = left_r - 8'd1;
        if (left_nxt == 8'd0) phase_nxt = PH_COM_TAG;
      end
      PH_COM_TAG: begin
        if (b != TAG_OCTETS) begin
          err_nxt = ST_COM_TAG; phase_nxt = PH_HALT;
        end else phase_nxt = PH_COM_LEN;
      end
      PH_COM_LEN: begin
        comlen_nxt = b;
        left_nxt   = b;
        phase_nxt  = (b == 8'd0) ? PH_PDU_TYPE : PH_COM_BODY;
      end
      PH_COM_BODY: begin
        emit     = 1'b1;
        left_nxt = left_r - 8'd1;
        if (left_nxt == 8'd0) phase_nxt = PH_PDU_TYPE;
      end
      PH_PDU_TYPE: begin
        pdu_nxt = b; phase_nxt = PH_PDU_LEN;
      end
      PH_PDU_LEN: begin
        priority if (pdu_r == resp_code_r) begin
          idx_nxt = 2'd0; phase_nxt = PH_INT_TAG;
        end else if (pdu_r == trap_code_r) phase_nxt = PH_OID_TAG;
        else phase_nxt = PH_DONE;
      end
      PH_INT_TAG: begin
        if (b != TAG_INTEGER) begin
          err_nxt = ST_INT_TAG; phase_nxt = PH_HALT;
        end else phase_nxt = PH_INT_LEN;
      end
      PH_INT_LEN: begin
        left_nxt = b;
        if (b != 8'd0) phase_nxt = PH_INT_BODY;
        else if (idx_r == INT_LAST) phase_nxt = PH_DONE;
        else begin
          idx_nxt = idx_r + 2'd1; phase_nxt = PH_INT_TAG;
        end
      end
      PH_INT_BODY: begin
        int_nxt[idx_r] = {int_r[idx_r][23:0], b};
        left_nxt       = left_r - 8'd1;
        if (left_nxt == 8'd0) begin
          if (idx_r == INT_LAST) phase_nxt = PH_DONE;
          else begin
            idx_nxt = idx_r + 2'd1; phase_nxt = PH_INT_TAG;
          end
        end
      end
      PH_OID_TAG: begin
        if (b != TAG_OID) begin
          err_nxt = ST_TRAP_FMT; phase_nxt = PH_HALT;
        end else phase_nxt = PH_OID_LEN;
      end
      PH_OID_LEN: begin
        left_nxt  = b;
        phase_nxt = (b == 8'd0) ? PH_IP_TAG : PH_OID_BODY;
      end
      PH_OID_BODY: begin
        left_nxt = left_r - 8'd1;
        if (left_nxt == 8'd0) phase_nxt = PH_IP_TAG;
      end
      PH_IP_TAG: begin
        if (b != TAG_IPADDR) begin
          err_nxt = ST_TRAP_FMT; phase_nxt = PH_HALT;
        end else phase_nxt = PH_IP_LEN;
      end
      PH_IP_LEN: begin
        left_nxt = 8'd4; phase_nxt = PH_IP_BODY;
      end
      PH_IP_BODY: begin
        addr_nxt = {addr_r[23:0], b};
        left_nxt = left_r - 8'd1;
        if (left_nxt == 8'd0) phase_nxt = PH_DONE;
      end
      default: ;
    endcase
  end

  always_comb begin
    priority if (err_nxt == ST_NO_SEQ) status = ST_NO_SEQ;
    else if (count_nxt < 9'd2 || {1'b0, total_nxt} != count_nxt - 9'd2) status = ST_LEN_MIS;
    else if (err_nxt != ST_OK) status = err_nxt;
    else if (phase_nxt != PH_DONE) status = ST_TRUNC;
    else status = ST_OK;
  end

  always_comb begin
    res       = '0;
    res_valid = in_fire && (in_data.end_of_message || emit);
    if (in_data.end_of_message) begin
      res.kind             = 1'b1;
      res.status           = status;
      res.version          = ver_nxt;
      res.pdu_type         = pdu_nxt;
      res.request_id       = int_nxt[0];
      res.error_status     = int_nxt[1];
      res.error_index      = int_nxt[2];
      res.agent_address    = addr_nxt;
      res.community_length = comlen_nxt;
    end else begin
      res.community_byte   = b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_code_r <= RESPONSE_CODE_RST;
      trap_code_r <= TRAP_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_RESPONSE_CODE) resp_code_r <= cfg_data;
      else if (cfg_index == CFG_TRAP_CODE) trap_code_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_data.end_of_message)) begin
      phase_r  <= PH_SEQ_TAG;
      count_r  <= '0;
      total_r  <= '0;
      left_r   <= '0;
      err_r    <= ST_OK;
      ver_r    <= '0;
      pdu_r    <= '0;
      comlen_r <= '0;
      int_r    <= '{default: '0};
      idx_r    <= '0;
      addr_r   <= '0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      total_r  <= total_nxt;
      left_r   <= left_nxt;
      err_r    <= err_nxt;
      ver_r    <= ver_nxt;
      pdu_r    <= pdu_nxt;
      comlen_r <= comlen_nxt;
      int_r    <= int_nxt;
      idx_r    <= idx_nxt;
      addr_r   <= addr_nxt;
    end
  end

  // output register with one-entry skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  `SBP_ASSERT(a_skid_implies_out, skid_valid_r |-> out_valid_r, "skid full with empty output")
  `SBP_ASSERT(a_halt_has_error, (phase_r == PH_HALT) |-> (err_r != ST_OK), "halt without error")
  `SBP_ASSERT(a_rearm_after_end, (in_fire && in_data.end_of_message) |=> (phase_r == PH_SEQ_TAG && count_r == 9'd0), "parser not re-armed")
  `SBP_ASSERT(a_byte_result_clean, (out_valid_r && !out_r.kind) |-> (out_r.status == ST_OK && out_r.version == 32'd0 && out_r.community_length == 8'd0), "community result carries summary fields")
  `SBP_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (!out_valid_r && !skid_valid_r), "result stages not empty after reset")

endmodule

FILE: verif/snmp_ber_header_parser_tb.sv
// ----------------------------------------------------------------------------
// SNMP BER header parser testbench
// Feeds SNMP v1 messages byte by byte through the valid/ready input and
// checks every community byte and end-of-message summary against a
// behavioural parser kept in step with each accepted transfer. A directed
// set covers tag errors, truncation, length checks and the byte count limit;
// random phases then vary the PDU codes, traffic gaps and output back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module snmp_ber_header_parser_tb;
  import sbp_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BYTES = 20;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  sbp_in_t                in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  sbp_out_t               out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data = '0;

  snmp_ber_header_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  sbp_in_t    pending_bytes[$];
  sbp_out_t   expected_results[$];
  logic [7:0] frame[$];
  bit         in_taken = 1'b0;
  bit         steady = 1'b0;
  int         hold_requests = 0;
  int         holds_served = 0;
  int         hold_left = 0;
  int         fail_count = 0;
  int         cycles = 0;
  int         phase_items = 0;

  // Parser model state
  logic [7:0]  response_code;
  logic [7:0]  trap_code;
  sbp_phase_t  phase;
  logic [8:0]  byte_cnt;
  logic [7:0]  declared_len;
  logic [7:0]  remaining;
  logic [2:0]  err_code;
  logic [31:0] version_acc;
  logic [7:0]  pdu_code;
  logic [7:0]  community_len;
  logic [31:0] int_val[3];
  int          int_idx;
  logic [31:0] agent_addr;

  task automatic report_error(input string msg);
    fail_count++;
    if (fail_count <= 100) $display("[%0t] error: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic void clear_parse();
    phase         = PH_SEQ_TAG;
    byte_cnt      = '0;
    declared_len  = '0;
    remaining     = '0;
    err_code      = ST_OK;
    version_acc   = '0;
    pdu_code      = '0;
    community_len = '0;
    int_val[0]    = '0;
    int_val[1]    = '0;
    int_val[2]    = '0;
    agent_addr    = '0;
    int_idx       = 0;
  endfunction

  function automatic void halt(input logic [2:0] code);
    err_code = code;
    phase    = PH_HALT;
  endfunction

  function automatic void next_int();
    int_idx++;
    phase = (int_idx >= 3) ? PH_DONE : PH_INT_TAG;
  endfunction

  function automatic void parse_byte(input sbp_in_t it);
    logic [7:0] b;
    bit         community;
    sbp_out_t   r;
    b = it.data_byte;
    community = 1'b0;
    if (byte_cnt != BYTE_COUNT_MAX) byte_cnt++;
    case (phase)
      PH_SEQ_TAG:   if (b != TAG_SEQUENCE) halt(ST_NO_SEQ); else phase = PH_TOTAL_LEN;
      PH_TOTAL_LEN: begin
        declared_len = b;
        phase = PH_VER_TAG;
      end
      PH_VER_TAG:   if (b != TAG_INTEGER) halt(ST_VER_TAG); else phase = PH_VER_LEN;
      PH_VER_LEN: begin
        remaining = b;
        phase = (b == 8'd0) ? PH_COM_TAG : PH_VER_BODY;
      end
      PH_VER_BODY: begin
        version_acc = {version_acc[23:0], b};
        remaining--;
        if (remaining == 8'd0) phase = PH_COM_TAG;
      end
      PH_COM_TAG:   if (b != TAG_OCTETS) halt(ST_COM_TAG); else phase = PH_COM_LEN;
      PH_COM_LEN: begin
        community_len = b;
        remaining = b;
        phase = (b == 8'd0) ? PH_PDU_TYPE : PH_COM_BODY;
      end
      PH_COM_BODY: begin
        community = 1'b1;
        remaining--;
        if (remaining == 8'd0) phase = PH_PDU_TYPE;
      end
      PH_PDU_TYPE: begin
        pdu_code = b;
        phase = PH_PDU_LEN;
      end
      PH_PDU_LEN: begin
        // response wins when both codes match
        if (pdu_code == response_code) begin
          int_idx = 0;
          phase = PH_INT_TAG;
        end else if (pdu_code == trap_code) begin
          phase = PH_OID_TAG;
        end else begin
          phase = PH_DONE;
        end
      end
      PH_INT_TAG:   if (b != TAG_INTEGER) halt(ST_INT_TAG); else phase = PH_INT_LEN;
      PH_INT_LEN: begin
        remaining = b;
        if (b == 8'd0) next_int(); else phase = PH_INT_BODY;
      end
      PH_INT_BODY: begin
        int_val[int_idx] = {int_val[int_idx][23:0], b};
        remaining--;
        if (remaining == 8'd0) next_int();
      end
      PH_OID_TAG:   if (b != TAG_OID) halt(ST_TRAP_FMT); else phase = PH_OID_LEN;
      PH_OID_LEN: begin
        remaining = b;
        phase = (b == 8'd0) ? PH_IP_TAG : PH_OID_BODY;
      end
      PH_OID_BODY: begin
        remaining--;
        if (remaining == 8'd0) phase = PH_IP_TAG;
      end
      PH_IP_TAG:    if (b != TAG_IPADDR) halt(ST_TRAP_FMT); else phase = PH_IP_LEN;
      PH_IP_LEN: begin
        // length byte ignored, always four octets
        remaining = 8'd4;
        phase = PH_IP_BODY;
      end
      PH_IP_BODY: begin
        agent_addr = {agent_addr[23:0], b};
        remaining--;
        if (remaining == 8'd0) phase = PH_DONE;
      end
      default: ;
    endcase
    r = '0;
    if (it.end_of_message) begin
      r.kind = 1'b1;
      if (err_code == ST_NO_SEQ) r.status = ST_NO_SEQ;
      else if (byte_cnt < 9'd2 || 9'(declared_len) != byte_cnt - 9'd2) r.status = ST_LEN_MIS;
      else if (err_code != ST_OK) r.status = err_code;
      else if (phase != PH_DONE) r.status = ST_TRUNC;
      else r.status = ST_OK;
      r.version          = version_acc;
      r.pdu_type         = pdu_code;
      r.request_id       = int_val[0];
      r.error_status     = int_val[1];
      r.error_index      = int_val[2];
      r.agent_address    = agent_addr;
      r.community_length = community_len;
      expected_results.insert(expected_results.size(), r);
      clear_parse();
    end else if (community) begin
      r.community_byte = b;
      expected_results.insert(expected_results.size(), r);
    end
  endfunction

  // Sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || in_taken) begin
      if (pending_bytes.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
        in_data  <= pending_bytes.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_ready    <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 37);
    end
  end

  // Transfer monitor and result check
  always @(posedge clk) begin : monitor
    sbp_out_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_error("result transfer with nothing expected");
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 32'(out_data.kind), 32'(want.kind));
          check_field("community_byte", 32'(out_data.community_byte),
                      32'(want.community_byte));
          check_field("status", 32'(out_data.status), 32'(want.status));
          check_field("version", out_data.version, want.version);
          check_field("pdu_type", 32'(out_data.pdu_type), 32'(want.pdu_type));
          check_field("request_id", out_data.request_id, want.request_id);
          check_field("error_status", out_data.error_status, want.error_status);
          check_field("error_index", out_data.error_index, want.error_index);
          check_field("agent_address", out_data.agent_address, want.agent_address);
          check_field("community_length", 32'(out_data.community_length),
                      32'(want.community_length));
        end
      end
      if (in_valid && in_ready) parse_byte(in_data);
      in_taken <= in_valid && in_ready;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_RESPONSE_CODE) response_code = val;
    else trap_code = val;
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (!(pending_bytes.size() == 0 && (!in_valid || in_taken) &&
             expected_results.size() == 0));
    repeat (4) @(negedge clk);
  endtask

  task automatic put_tlv(input logic [7:0] tag, input int len, input int fill);
    frame.insert(frame.size(), tag);
    frame.insert(frame.size(), 8'(len));
    repeat (len) frame.insert(frame.size(), fill < 0 ? 8'($urandom) : 8'(fill));
  endtask

  task automatic put_ip(input logic [7:0] len_byte, input int fill);
    frame.insert(frame.size(), TAG_IPADDR);
    frame.insert(frame.size(), len_byte);
    repeat (4) frame.insert(frame.size(), fill < 0 ? 8'($urandom) : 8'(fill));
  endtask

  // Header up to and including the PDU length byte
  task automatic build_head(input logic [7:0] pdu, input int vlen, input int vfill,
                            input int clen);
    frame = {TAG_SEQUENCE, 8'h00};
    put_tlv(TAG_INTEGER, vlen, vfill);
    put_tlv(TAG_OCTETS, clen, -1);
    frame.insert(frame.size(), pdu);
    frame.insert(frame.size(), 8'($urandom));
  endtask

  task automatic queue_frame(input bit fix_len);
    sbp_in_t it;
    if (fix_len && frame.size() >= 2) frame[1] = 8'(frame.size() - 2);
    foreach (frame[i]) begin
      it.data_byte      = frame[i];
      it.end_of_message = (i == frame.size() - 1);
      pending_bytes.insert(pending_bytes.size(), it);
    end
    phase_items += frame.size();
  endtask

  task automatic random_frame();
    int         sel;
    int         cut;
    logic [7:0] pdu;
    sel = $urandom_range(99);
    if (sel < 8) begin
      frame.delete();
      repeat ($urandom_range(1, 6)) frame.insert(frame.size(), 8'($urandom));
      queue_frame(1'b0);
    end else begin
      sel = $urandom_range(99);
      pdu = (sel < 40) ? response_code : (sel < 80) ? trap_code : 8'($urandom);
      build_head(pdu, $urandom_range(0, 5), -1,
                 ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12));
      if (pdu == response_code) begin
        repeat (3) put_tlv(TAG_INTEGER, $urandom_range(0, 6), -1);
      end else if (pdu == trap_code) begin
        put_tlv(TAG_OID, $urandom_range(0, 8), -1);
        put_ip(8'($urandom), -1);
      end
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 3)) frame.insert(frame.size(), 8'($urandom));
      sel = $urandom_range(99);
      if (sel < 10) begin
        cut = $urandom_range(1, frame.size() - 1);
        while (frame.size() > cut) void'(frame.pop_back());
      end else if (sel < 20) begin
        frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
      end else if (sel < 27) begin
        frame[1] = 8'($urandom);
      end
      queue_frame(!(sel >= 20 && sel < 27));
    end
  endtask

  initial begin
    response_code = RESPONSE_CODE_RST;
    trap_code     = TRAP_CODE_RST;
    clear_parse();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // receiver holds off as the directed set starts to stream in
    hold_requests++;

    // Directed messages at reset codes
    frame = {8'h00};
    queue_frame(1'b0);
    frame = {TAG_SEQUENCE};
    queue_frame(1'b0);
    frame = {TAG_SEQUENCE, 8'h00};
    queue_frame(1'b1);
    build_head(response_code, 5, 'hFF, 3);
    put_tlv(TAG_INTEGER, 4, 'hFF);
    put_tlv(TAG_INTEGER, 4, 'h80);
    put_tlv(TAG_INTEGER, 0, 0);
    queue_frame(1'b1);
    build_head(response_code, 0, 0, 0);
    put_tlv(TAG_INTEGER, 5, 'h7F);
    put_tlv(TAG_INTEGER, 1, 0);
    put_tlv(TAG_INTEGER, 2, 1);
    queue_frame(1'b1);
    build_head(trap_code, 1, 0, 2);
    put_tlv(TAG_OID, 3, -1);
    put_ip(8'hFF, 'hFF);
    frame.insert(frame.size(), 8'($urandom));
    frame.insert(frame.size(), 8'($urandom));
    queue_frame(1'b1);
    build_head(trap_code, 2, 'h01, 1);
    put_tlv(TAG_OID, 0, 0);
    put_ip(8'h04, 0);
    queue_frame(1'b1);
    build_head(8'h00, 1, -1, 5);
    queue_frame(1'b1);
    build_head(response_code, 1, -1, 1);
    frame[2] = 8'h03;
    queue_frame(1'b1);
    build_head(response_code, 1, -1, 1);
    frame[5] = 8'h05;
    queue_frame(1'b1);
    build_head(response_code, 0, 0, 0);
    put_tlv(TAG_INTEGER, 1, -1);
    put_tlv(8'h03, 1, -1);
    put_tlv(TAG_INTEGER, 1, -1);
    queue_frame(1'b1);
    build_head(trap_code, 0, 0, 0);
    put_tlv(8'h07, 1, -1);
    put_ip(8'h04, -1);
    queue_frame(1'b1);
    build_head(trap_code, 0, 0, 0);
    put_tlv(TAG_OID, 2, -1);
    frame.insert(frame.size(), 8'h41);
    frame.insert(frame.size(), 8'h04);
    queue_frame(1'b1);
    // length mismatch outranks the version tag error
    build_head(response_code, 1, -1, 1);
    frame[2] = 8'h03;
    queue_frame(1'b0);
    build_head(8'h00, 0, 0, 0);
    frame[0] = 8'h31;
    queue_frame(1'b0);
    // final byte lands inside the community string
    build_head(response_code, 1, -1, 4);
    repeat (3) void'(frame.pop_back());
    queue_frame(1'b1);
    build_head(response_code, 4, -1, 0);
    put_tlv(TAG_INTEGER, 4, -1);
    put_tlv(TAG_INTEGER, 4, -1);
    repeat (2) void'(frame.pop_back());
    queue_frame(1'b1);
    build_head(8'h00, 0, 0, 255);
    while (frame.size() < 258) frame.insert(frame.size(), 8'($urandom));
    queue_frame(1'b1);
    // byte count saturates rather than wrapping onto a zero total length
    build_head(8'h00, 0, 0, 255);
    while (frame.size() < 514) frame.insert(frame.size(), 8'($urandom));
    frame[1] = 8'd0;
    queue_frame(1'b0);
    wait_drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: ;
        1: begin
          write_reg(CFG_RESPONSE_CODE, 8'h00);
          write_reg(CFG_TRAP_CODE, 8'hFF);
        end
        2: begin
          write_reg(CFG_RESPONSE_CODE, 8'hFF);
          write_reg(CFG_TRAP_CODE, 8'h00);
        end
        3: begin
          write_reg(CFG_RESPONSE_CODE, 8'h55);
          write_reg(CFG_TRAP_CODE, 8'h55);
        end
        default: begin
          write_reg(CFG_RESPONSE_CODE, 8'($urandom));
          write_reg(CFG_TRAP_CODE,
                    ($urandom_range(3) == 0) ? response_code : 8'($urandom));
        end
      endcase
      steady = (p == 5);
      if (p == 4) hold_requests++;
      phase_items = 0;
      while (phase_items < (steady ? 4 * PHASE_BYTES : PHASE_BYTES)) random_frame();
      wait_drain();
    end
    steady = 1'b0;

    repeat (20) @(negedge clk);
    if (expected_results.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_results.size()));
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sbp_pkg.sv
rtl/snmp_ber_header_parser.sv
verif/snmp_ber_header_parser_tb.sv
